FILE: src/mac_pkg.sv
// Shared types, codes and constants for the motion alarm controller.
`timescale 1ns / 1ps

package mac_pkg;

   localparam int TICKS_PER_SECOND = 1000;

   localparam int OP_W      = 2;
   localparam int BUTTON_W  = 2;
   localparam int SAMPLE_W  = 12;
   localparam int DEBOUNCE_W = 16;
   localparam int SECONDS_W = 8;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int BOUND_W   = SAMPLE_W + 2;

   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_PRESS  = 2'd1;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

   localparam logic [BUTTON_W-1:0] BTN_ARM    = 2'd0;
   localparam logic [BUTTON_W-1:0] BTN_SEARCH = 2'd1;
   localparam logic [BUTTON_W-1:0] BTN_JOY    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECONDS  = 2'd3;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd200;
   localparam logic [SAMPLE_W-1:0]   CENTER_RESET   = 12'd2048;
   localparam logic [SAMPLE_W-1:0]   MARGIN_RESET   = 12'd2000;

   typedef enum logic [1:0] {
      LED_OFF    = 2'd0,
      LED_GRN    = 2'd1,
      LED_RED    = 2'd2,
      LED_YELLOW = 2'd3
   } led_type;

   typedef struct packed {
      logic    armed;
      logic    motion_latched;
      logic    confirm_pending;
      led_type led_color;
      logic    buzzer_on;
      logic    matrix_pattern;
   } rsp_type;

endpackage

FILE: src/mac_if.sv
// Channel interfaces: request, response and register write.
`timescale 1ns / 1ps

interface mac_req_if;
   import mac_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [BUTTON_W-1:0] button;
   logic [SAMPLE_W-1:0] x_sample;
   logic [SAMPLE_W-1:0] y_sample;
   modport source (output valid, op, button, x_sample, y_sample, input ready);
   modport sink   (input valid, op, button, x_sample, y_sample, output ready);
endinterface

interface mac_rsp_if;
   import mac_pkg::*;
   logic       valid;
   logic       ready;
   logic       armed;
   logic       motion_latched;
   logic       confirm_pending;
   logic [1:0] led_color;
   logic       buzzer_on;
   logic       matrix_pattern;
   modport source (output valid, armed, motion_latched, confirm_pending, led_color,
                   buzzer_on, matrix_pattern, input ready);
   modport sink   (input valid, armed, motion_latched, confirm_pending, led_color,
                   buzzer_on, matrix_pattern, output ready);
endinterface

interface mac_csr_if;
   import mac_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/motion_alarm_controller_unit.sv
// Motion alarm controller: arm toggle, motion latch, two-press acknowledge, buzzer timeout.
// Usage:
//   req_chan carries one event per transaction: a 1 ms tick, a button press or a
//   joystick sample. rsp_chan returns exactly one status transaction per request,
//   in order. csr_chan writes the four registers (debounce, centre, margin, alarm
//   seconds); it is always ready. It must be written only while the block is idle;
//   the block does not enforce this.
// Throughput: one request per cycle while req_chan.ready is high; each event is
//   resolved in a single pass of flag logic plus at most one 32-bit counter compare
//   between the state registers and the output buffer.
// Stall: a two-entry output buffer (response register and skid register) holds
//   results; req_chan.ready falls only when both are full and drops back as soon
//   as the receiver takes one.
// Reset: synchronous, active high; clears all flags, counters and buffers and
//   loads the register defaults (debounce 200, centre 2048, margin 2000, alarm
//   seconds 0). Presses within the first debounce window after reset are dropped.
`timescale 1ns / 1ps

module motion_alarm_controller_unit (
   input  logic     clock,
   input  logic     reset,
   mac_req_if.sink  req_chan,
   mac_rsp_if.source rsp_chan,
   mac_csr_if.sink  csr_chan
);
   import mac_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [SAMPLE_W-1:0]   center_ff;
   logic [SAMPLE_W-1:0]   margin_ff;
   logic [TIME_W-1:0]     alarm_limit_ff;

   logic [TIME_W-1:0] since_press_ff, since_press_in;
   logic [TIME_W-1:0] alarm_age_ff, alarm_age_in;
   logic    armed_ff, armed_in;
   logic    motion_ff, motion_in;
   logic    confirm_ff, confirm_in;
   logic    buzzer_ff, buzzer_in;
   led_type led_ff, led_in;
   logic    pattern_ff, pattern_in;

   rsp_type out_ff, out_in, skid_ff, skid_in, result;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic accept, take;
   logic signed [BOUND_W-1:0] bound_lo, bound_hi, x_s, y_s;
   logic moved;
   logic [TIME_W-1:0] age_now;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !skid_valid_ff;
   assign accept = req_chan.valid && req_chan.ready;
   assign take   = out_valid_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RESET;
         center_ff      <= CENTER_RESET;
         margin_ff      <= MARGIN_RESET;
         alarm_limit_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DEBOUNCE: debounce_ff <= csr_chan.data;
            CSR_CENTER:   center_ff   <= csr_chan.data[SAMPLE_W-1:0];
            CSR_MARGIN:   margin_ff   <= csr_chan.data[SAMPLE_W-1:0];
            CSR_SECONDS:  alarm_limit_ff <=
               TIME_W'(int'(csr_chan.data[SECONDS_W-1:0]) * TICKS_PER_SECOND);
            default: ;
         endcase
      end
   end

   always_comb begin
      bound_lo = $signed({2'b00, center_ff}) - $signed({2'b00, margin_ff});
      bound_hi = $signed({2'b00, center_ff}) + $signed({2'b00, margin_ff});
      x_s      = $signed({2'b00, req_chan.x_sample});
      y_s      = $signed({2'b00, req_chan.y_sample});
      moved    = (x_s < bound_lo) || (x_s > bound_hi) ||
                 (y_s < bound_lo) || (y_s > bound_hi);
   end

   always_comb begin
      since_press_in = since_press_ff;
      alarm_age_in   = alarm_age_ff;
      armed_in       = armed_ff;
      motion_in      = motion_ff;
      confirm_in     = confirm_ff;
      buzzer_in      = buzzer_ff;
      led_in         = led_ff;
      pattern_in     = pattern_ff;
      age_now        = alarm_age_ff;
      unique case (req_chan.op)
         OP_TICK: begin
            since_press_in = since_press_ff + TIME_W'(1);
            alarm_age_in   = alarm_age_ff + TIME_W'(1);
         end
         OP_PRESS: begin
            if (since_press_ff >= TIME_W'(debounce_ff)) begin
               since_press_in = '0;
               if (req_chan.button == BTN_ARM) begin
                  armed_in   = !armed_ff;
                  led_in     = armed_ff ? LED_OFF : LED_GRN;
                  pattern_in = 1'b0;
               end else if (req_chan.button == BTN_JOY && motion_ff) begin
                  if (!confirm_ff) begin
                     confirm_in = 1'b1;
                     led_in     = LED_YELLOW;
                  end else begin
                     motion_in  = 1'b0;
                     confirm_in = 1'b0;
                     led_in     = LED_GRN;
                     pattern_in = 1'b0;
                  end
               end
            end
         end
         OP_SAMPLE: begin
            if (armed_ff) begin
               if (moved && !motion_ff) begin
                  motion_in    = 1'b1;
                  alarm_age_in = '0;
                  age_now      = '0;
                  led_in       = LED_RED;
                  buzzer_in    = 1'b1;
                  pattern_in   = 1'b1;
               end
               if (motion_in && !confirm_ff && age_now >= alarm_limit_ff) begin
                  buzzer_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      result = '{armed: armed_in, motion_latched: motion_in, confirm_pending: confirm_in,
                 led_color: led_in, buzzer_on: buzzer_in, matrix_pattern: pattern_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_press_ff <= '0;
         alarm_age_ff   <= '0;
         armed_ff       <= 1'b0;
         motion_ff      <= 1'b0;
         confirm_ff     <= 1'b0;
         buzzer_ff      <= 1'b0;
         led_ff         <= LED_OFF;
         pattern_ff     <= 1'b0;
      end else if (accept) begin
         since_press_ff <= since_press_in;
         alarm_age_ff   <= alarm_age_in;
         armed_ff       <= armed_in;
         motion_ff      <= motion_in;
         confirm_ff     <= confirm_in;
         buzzer_ff      <= buzzer_in;
         led_ff         <= led_in;
         pattern_ff     <= pattern_in;
      end
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.armed           = out_ff.armed;
   assign rsp_chan.motion_latched  = out_ff.motion_latched;
   assign rsp_chan.confirm_pending = out_ff.confirm_pending;
   assign rsp_chan.led_color       = out_ff.led_color;
   assign rsp_chan.buzzer_on       = out_ff.buzzer_on;
   assign rsp_chan.matrix_pattern  = out_ff.matrix_pattern;

endmodule

FILE: tb/mac_status_checker.sv
// Status checker: predicts every controller status transaction and compares it field by field.
`timescale 1ns / 1ps

module mac_status_checker
   import mac_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mac_req_if   req_chan,
   mac_rsp_if   rsp_chan,
   mac_csr_if   csr_chan,
   output int   fail_count,
   output int   pending
);

   localparam logic [TIME_W-1:0] MS_PER_SECOND = TIME_W'(TICKS_PER_SECOND);

   logic [DEBOUNCE_W-1:0] debounce_ms;
   logic [SAMPLE_W-1:0]   centre_value;
   logic [SAMPLE_W-1:0]   motion_margin;
   logic [SECONDS_W-1:0]  alarm_seconds;

   logic [TIME_W-1:0] ms_now;
   logic [TIME_W-1:0] last_press_ms;
   logic [TIME_W-1:0] alarm_begin_ms;
   rsp_type           status;
   rsp_type           status_q[$];
   int                failures;

   function automatic logic off_centre(input logic [SAMPLE_W-1:0] v);
      int lo;
      int hi;
      lo = int'(centre_value) - int'(motion_margin);
      hi = int'(centre_value) + int'(motion_margin);
      return (int'(v) < lo) || (int'(v) > hi);
   endfunction

   task automatic apply_event(input logic [OP_W-1:0] op, input logic [BUTTON_W-1:0] button,
                              input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
      logic [TIME_W-1:0] since;
      case (op)
         OP_TICK: ms_now = ms_now + 1'b1;
         OP_PRESS: begin
            since = ms_now - last_press_ms;
            if (since >= debounce_ms) begin
               last_press_ms = ms_now;
               if (button == BTN_ARM) begin
                  status.armed = !status.armed;
                  status.led_color = status.armed ? LED_GRN : LED_OFF;
                  status.matrix_pattern = 1'b0;
               end else if (button == BTN_JOY && status.motion_latched) begin
                  if (!status.confirm_pending) begin
                     status.confirm_pending = 1'b1;
                     status.led_color = LED_YELLOW;
                  end else begin
                     status.motion_latched = 1'b0;
                     status.confirm_pending = 1'b0;
                     status.led_color = LED_GRN;
                     status.matrix_pattern = 1'b0;
                  end
               end
            end
         end
         OP_SAMPLE: begin
            if (status.armed) begin
               if ((off_centre(x) || off_centre(y)) && !status.motion_latched) begin
                  status.motion_latched = 1'b1;
                  alarm_begin_ms = ms_now;
                  status.led_color = LED_RED;
                  status.buzzer_on = 1'b1;
                  status.matrix_pattern = 1'b1;
               end
               if (status.motion_latched && !status.confirm_pending) begin
                  since = ms_now - alarm_begin_ms;
                  if (since / MS_PER_SECOND >= alarm_seconds)
                     status.buzzer_on = 1'b0;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         debounce_ms = DEBOUNCE_RESET;
         centre_value = CENTER_RESET;
         motion_margin = MARGIN_RESET;
         alarm_seconds = '0;
         ms_now = '0;
         last_press_ms = '0;
         alarm_begin_ms = '0;
         status = '0;
         status_q.delete();
         failures = 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_DEBOUNCE: debounce_ms = csr_chan.data[DEBOUNCE_W-1:0];
               CSR_CENTER:   centre_value = csr_chan.data[SAMPLE_W-1:0];
               CSR_MARGIN:   motion_margin = csr_chan.data[SAMPLE_W-1:0];
               CSR_SECONDS:  alarm_seconds = csr_chan.data[SECONDS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.armed = rsp_chan.armed;
            got.motion_latched = rsp_chan.motion_latched;
            got.confirm_pending = rsp_chan.confirm_pending;
            got.led_color = led_type'(rsp_chan.led_color);
            got.buzzer_on = rsp_chan.buzzer_on;
            got.matrix_pattern = rsp_chan.matrix_pattern;
            if (status_q.size() == 0) begin
               $error("status transaction with none expected");
               failures++;
            end else begin
               want = status_q.pop_front();
               if (got.armed !== want.armed) begin
                  $error("armed: expected %0d, got %0d", want.armed, got.armed);
                  failures++;
               end
               if (got.motion_latched !== want.motion_latched) begin
                  $error("motion_latched: expected %0d, got %0d",
                         want.motion_latched, got.motion_latched);
                  failures++;
               end
               if (got.confirm_pending !== want.confirm_pending) begin
                  $error("confirm_pending: expected %0d, got %0d",
                         want.confirm_pending, got.confirm_pending);
                  failures++;
               end
               if (got.led_color !== want.led_color) begin
                  $error("led_color: expected %0d, got %0d", want.led_color, got.led_color);
                  failures++;
               end
               if (got.buzzer_on !== want.buzzer_on) begin
                  $error("buzzer_on: expected %0d, got %0d", want.buzzer_on, got.buzzer_on);
                  failures++;
               end
               if (got.matrix_pattern !== want.matrix_pattern) begin
                  $error("matrix_pattern: expected %0d, got %0d",
                         want.matrix_pattern, got.matrix_pattern);
                  failures++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            apply_event(req_chan.op, req_chan.button, req_chan.x_sample, req_chan.y_sample);
            status_q.push_back(status);
         end
      end
      fail_count <= failures;
      pending <= status_q.size();
   end

endmodule

FILE: tb/tb_motion_alarm_controller_unit.sv
// Testbench top: drives events and register writes into the motion alarm controller.
`timescale 1ns / 1ps

module tb_motion_alarm_controller_unit;
   import mac_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
   localparam logic [OP_W-1:0]     OP_UNUSED  = 2'd3;
   localparam logic [BUTTON_W-1:0] BTN_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic burst = 1'b0;
   int   fail_count;
   int   pending;

   logic [SAMPLE_W-1:0] cur_centre;
   logic [SAMPLE_W-1:0] cur_margin;

   mac_req_if req_chan ();
   mac_rsp_if rsp_chan ();
   mac_csr_if csr_chan ();

   motion_alarm_controller_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   mac_status_checker status_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_chan.ready <= (hold == 0);
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            hold = burst ? 0 : $urandom_range(0, 13);
            rsp_chan.ready <= (hold == 0);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_event(input logic [OP_W-1:0] op, input logic [BUTTON_W-1:0] button,
                             input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.button <= button;
      req_chan.x_sample <= x;
      req_chan.y_sample <= y;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] debounce,
                               input logic [CSR_DATA_W-1:0] centre,
                               input logic [CSR_DATA_W-1:0] margin,
                               input logic [CSR_DATA_W-1:0] seconds);
      logic [CSR_IDX_W-1:0]  regs [4] = '{CSR_DEBOUNCE, CSR_CENTER, CSR_MARGIN, CSR_SECONDS};
      logic [CSR_DATA_W-1:0] value [4];
      value[0] = debounce;
      value[1] = centre;
      value[2] = margin;
      value[3] = seconds;
      cur_centre = centre[SAMPLE_W-1:0];
      cur_margin = margin[SAMPLE_W-1:0];
      csr_chan.valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_chan.index <= regs[i];
         csr_chan.data <= value[i];
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int v;
      int m;
      if ($urandom_range(0, 1))
         return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      m = int'(cur_margin);
      v = int'(cur_centre) - m - 2 + int'($urandom_range(0, 2 * m + 4));
      if (v < 0)
         v = 0;
      if (v > SAMPLE_MAX)
         v = SAMPLE_MAX;
      return SAMPLE_W'(v);
   endfunction

   task automatic run_mix(input int count);
      int pick;
      logic [OP_W-1:0]     op;
      logic [BUTTON_W-1:0] button;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0)
            burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         op = pick < 40 ? OP_TICK : pick < 65 ? OP_PRESS : pick < 95 ? OP_SAMPLE : OP_UNUSED;
         pick = $urandom_range(0, 99);
         button = pick < 30 ? BTN_ARM : pick < 80 ? BTN_JOY : pick < 90 ? BTN_SEARCH : BTN_UNUSED;
         send_event(op, button, pick_sample(), pick_sample());
      end
   endtask

   // latch an alarm whatever the arm state, then let it run past its timeout
   task automatic run_long_alarm(input int ticks);
      send_event(OP_PRESS, BTN_ARM, cur_centre, cur_centre);
      send_event(OP_SAMPLE, BTN_JOY, '0, '0);
      send_event(OP_PRESS, BTN_ARM, cur_centre, cur_centre);
      send_event(OP_SAMPLE, BTN_JOY, SAMPLE_W'(SAMPLE_MAX), '0);
      for (int n = 0; n < ticks; n++) begin
         if (n % 64 == 0)
            burst = ($urandom_range(0, 3) == 0);
         send_event(OP_TICK, BUTTON_W'($urandom_range(0, 3)), pick_sample(), pick_sample());
         if ($urandom_range(0, 7) == 0)
            send_event(OP_SAMPLE, BTN_ARM, cur_centre, cur_centre);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op <= OP_TICK;
      req_chan.button <= BTN_ARM;
      req_chan.x_sample <= '0;
      req_chan.y_sample <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_DEBOUNCE;
      csr_chan.data <= '0;
      cur_centre = CENTER_RESET;
      cur_margin = MARGIN_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_event(OP_PRESS, BTN_ARM, '0, '0);
      send_event(OP_SAMPLE, BTN_ARM, '0, SAMPLE_W'(SAMPLE_MAX));
      send_event(OP_UNUSED, BTN_ARM, '0, '0);
      send_event(OP_TICK, BTN_ARM, '0, '0);
      settle();

      write_config(16'd1, CSR_DATA_W'(CENTER_RESET), CSR_DATA_W'(MARGIN_RESET), 16'd1);
      send_event(OP_PRESS, BTN_ARM, '0, '0);
      send_event(OP_PRESS, BTN_ARM, '0, '0);
      send_event(OP_SAMPLE, BTN_ARM, CENTER_RESET, CENTER_RESET);
      send_event(OP_SAMPLE, BTN_ARM, 12'd48, 12'd4048);
      send_event(OP_SAMPLE, BTN_ARM, 12'd4049, CENTER_RESET);
      send_event(OP_PRESS, BTN_JOY, '0, '0);
      send_event(OP_TICK, BTN_ARM, '0, '0);
      send_event(OP_PRESS, BTN_JOY, '0, '0);
      send_event(OP_SAMPLE, BTN_ARM, '0, '0);
      send_event(OP_TICK, BTN_ARM, '0, '0);
      send_event(OP_PRESS, BTN_SEARCH, '0, '0);
      send_event(OP_TICK, BTN_ARM, '0, '0);
      send_event(OP_PRESS, BTN_UNUSED, '0, '0);
      send_event(OP_TICK, BTN_ARM, '0, '0);
      send_event(OP_PRESS, BTN_JOY, '0, '0);
      send_event(OP_TICK, BTN_ARM, '0, '0);
      send_event(OP_PRESS, BTN_ARM, '0, '0);
      send_event(OP_UNUSED, BTN_UNUSED, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX));
      settle();

      write_config(16'd0, CSR_DATA_W'(CENTER_RESET), CSR_DATA_W'(MARGIN_RESET), 16'd0);
      run_mix(250);
      settle();
      write_config(16'd3, 16'd0, 16'd0, 16'd255);
      run_mix(200);
      settle();
      write_config(16'hFFFF, 16'hFFF, 16'hFFF, 16'd1);
      run_mix(80);
      settle();
      write_config(16'd1, 16'hFFF, 16'd0, 16'd2);
      run_mix(200);
      for (int p = 0; p < 3; p++) begin
         settle();
         write_config(CSR_DATA_W'($urandom_range(0, 4)), CSR_DATA_W'($urandom),
                      CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
         run_mix(150);
      end
      settle();
      write_config(16'd0, CSR_DATA_W'(CENTER_RESET), 16'd100, 16'd1);
      run_long_alarm(1050);
      run_mix(60);
      settle();

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
